// ----- rtl/epipole_table_fallback_lookup_macros.svh -----
// assertion helpers used by the checker file
`ifndef EPIPOLE_TABLE_FALLBACK_LOOKUP_MACROS_SVH
`define EPIPOLE_TABLE_FALLBACK_LOOKUP_MACROS_SVH

// plain clocked property with asynchronous active-low reset
`define ETFL_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// signal held while a transfer is stalled
`define ETFL_ASSERT_HELD(label, clk, rstn, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (vld && !rdy) |=> $stable(sig)) \
    else $error(msg);

`endif

// ----- rtl/etfl_pkg.sv -----
`default_nettype none

package etfl_pkg;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned COORD_W = 32;

  // operation codes
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_MKAVAIL = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // lookup hit levels
  localparam logic [1:0] LVL_EXACT    = 2'd0;
  localparam logic [1:0] LVL_CUR_WILD = 2'd1;
  localparam logic [1:0] LVL_GLOBAL   = 2'd2;

  localparam logic [KEY_W-1:0] WILDCARD_KEY = 16'hFFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_FETCH
  } state_e;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [KEY_W-1:0]   cur_poc;
    logic signed [KEY_W-1:0]   ref_poc;
    logic                      set_available;
    logic signed [COORD_W-1:0] vec_x;
    logic signed [COORD_W-1:0] vec_y;
    logic signed [COORD_W-1:0] vec_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [1:0]                hit_level;
    logic                      exact_present;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/epipole_table_fallback_lookup.sv -----
// keyed table of epipole vectors with fallback lookup
// input channel (in_valid_i / in_ready_o / in_data_i) carries one command per
// transfer: insert, lookup with fallback, or make-available by current number
// output channel (out_valid_o / out_ready_i / out_data_o) returns exactly one
// result transfer per command, in command order
// every command sweeps the used part of the table through one synchronous
// memory, one entry per cycle, read port feeding a compare stage; a lookup
// that hits then re-reads the winning entry, and an empty table skips the
// sweep; a new command is taken only once the previous one has loaded its
// result into the output register
// used entries always fill from index 0 upwards, so a fill counter replaces
// per-entry used bits; reset clears the counter and the control state only,
// no clearing pass is needed
// the result sits in an output register: a stalled receiver holds it there
// while the next command is already accepted and swept; that command waits in
// its final step until the register is free
`default_nettype none

module epipole_table_fallback_lookup
  import etfl_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COORD_BITS    = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  // one table entry as kept in memory
  typedef struct packed {
    logic                  avail;
    logic [KEY_W-1:0]      key_cur;
    logic [KEY_W-1:0]      key_ref;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } entry_t;

  entry_t mem [TABLE_ENTRIES];

  state_e state_q, state_d;

  in_item_t req_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // read port and compare stage
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  entry_t           rd_data_q;
  logic             scan_vld_q;
  logic [IDX_W-1:0] rd_idx_q;

  // match flags gathered during the sweep
  logic             ex_q, ex_av_q, l1_q, l2_q;
  logic [IDX_W-1:0] ex_idx_q, l1_idx_q, l2_idx_q;

  logic      out_vld_q;
  out_item_t out_q;
  logic      out_load;
  out_item_t out_d;

  logic in_xfer;
  logic out_free;
  logic m_ex, m_l1, m_l2, m_cur;
  logic any_hit;
  logic [IDX_W-1:0] hit_idx;
  logic [1:0]       hit_lvl;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_vld_q || out_ready_i;

  // key compares on the entry just read
  assign m_ex  = (rd_data_q.key_cur == req_q.cur_poc) && (rd_data_q.key_ref == req_q.ref_poc);
  assign m_l1  = (rd_data_q.key_cur == req_q.cur_poc) && (rd_data_q.key_ref == WILDCARD_KEY);
  assign m_l2  = (rd_data_q.key_cur == WILDCARD_KEY) && (rd_data_q.key_ref == WILDCARD_KEY);
  assign m_cur = (rd_data_q.key_cur == req_q.cur_poc);

  // fallback priority: exact, then (cur,-1), then (-1,-1)
  always_comb begin
    any_hit = 1'b1;
    hit_idx = l2_idx_q;
    hit_lvl = LVL_GLOBAL;
    if (ex_av_q) begin
      hit_idx = ex_idx_q;
      hit_lvl = LVL_EXACT;
    end else if (l1_q) begin
      hit_idx = l1_idx_q;
      hit_lvl = LVL_CUR_WILD;
    end else if (!l2_q) begin
      any_hit = 1'b0;
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      cnt_q      <= '0;
      scan_vld_q <= 1'b0;
      rd_idx_q   <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      scan_vld_q <= (state_q == S_SCAN);
      rd_idx_q   <= idx_q;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // sweep bookkeeping: first match at each level wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_q     <= 1'b0;
      ex_av_q  <= 1'b0;
      l1_q     <= 1'b0;
      l2_q     <= 1'b0;
      ex_idx_q <= '0;
      l1_idx_q <= '0;
      l2_idx_q <= '0;
    end else if (in_xfer) begin
      ex_q    <= 1'b0;
      ex_av_q <= 1'b0;
      l1_q    <= 1'b0;
      l2_q    <= 1'b0;
    end else if (scan_vld_q) begin
      if (m_ex && !ex_q) begin
        ex_q     <= 1'b1;
        ex_av_q  <= rd_data_q.avail;
        ex_idx_q <= rd_idx_q;
      end
      if (m_l1 && rd_data_q.avail && !l1_q) begin
        l1_q     <= 1'b1;
        l1_idx_q <= rd_idx_q;
      end
      if (m_l2 && rd_data_q.avail && !l2_q) begin
        l2_q     <= 1'b1;
        l2_idx_q <= rd_idx_q;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = idx_q;
    mem_we     = 1'b0;
    mem_waddr  = rd_idx_q;
    mem_wdata  = rd_data_q;
    out_load   = 1'b0;
    out_d      = '0;

    // make-available: write back the entry read last cycle with its mark set;
    // the read port is on the next entry by then, so no address collision
    if (scan_vld_q && (req_q.operation == OP_MKAVAIL) && m_cur) begin
      mem_we          = 1'b1;
      mem_waddr       = rd_idx_q;
      mem_wdata       = rd_data_q;
      mem_wdata.avail = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          idx_d   = '0;
          state_d = (cnt_q == '0) ? S_FINISH : S_SCAN;
        end
      end

      S_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q;
        if (CNT_W'(idx_q) == (cnt_q - CNT_W'(1))) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      // last entry sits in the compare stage
      S_DRAIN: begin
        state_d = S_FINISH;
      end

      S_FINISH: begin
        if (out_free) begin
          unique case (req_q.operation)
            OP_INSERT: begin
              mem_wdata.avail   = req_q.set_available;
              mem_wdata.key_cur = req_q.cur_poc;
              mem_wdata.key_ref = req_q.ref_poc;
              mem_wdata.x       = req_q.vec_x[COORD_BITS-1:0];
              mem_wdata.y       = req_q.vec_y[COORD_BITS-1:0];
              mem_wdata.z       = req_q.vec_z[COORD_BITS-1:0];
              out_load          = 1'b1;
              out_d.status      = STATUS_OK;
              if (ex_q) begin
                mem_we    = 1'b1;
                mem_waddr = ex_idx_q;
              end else if (cnt_q != CNT_W'(TABLE_ENTRIES)) begin
                mem_we    = 1'b1;
                mem_waddr = cnt_q[IDX_W-1:0];
                cnt_d     = cnt_q + CNT_W'(1);
              end else begin
                out_d.status = STATUS_FULL;
              end
              state_d = S_IDLE;
            end
            OP_LOOKUP: begin
              if (any_hit) begin
                mem_re    = 1'b1;
                mem_raddr = hit_idx;
                state_d   = S_FETCH;
              end else begin
                out_load     = 1'b1;
                out_d.status = STATUS_MISS;
                state_d      = S_IDLE;
              end
            end
            default: begin
              // make-available and the unused code answer with all zero
              out_load = 1'b1;
              state_d  = S_IDLE;
            end
          endcase
        end
      end

      // winning entry arrives; output register was freed in the step before
      S_FETCH: begin
        out_load            = 1'b1;
        out_d.status        = STATUS_OK;
        out_d.hit_level     = hit_lvl;
        out_d.exact_present = ex_av_q;
        out_d.out_x         = COORD_W'($signed(rd_data_q.x));
        out_d.out_y         = COORD_W'($signed(rd_data_q.y));
        out_d.out_z         = COORD_W'($signed(rd_data_q.z));
        state_d             = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/etfl_checker.sv -----
`default_nettype none
`include "epipole_table_fallback_lookup_macros.svh"

module etfl_checker
  import etfl_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_item_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  `ETFL_ASSERT(a_out_valid_held, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o, "result dropped while stalled")

  `ETFL_ASSERT_HELD(a_out_data_held, clk_i, rst_ni, out_valid_o, out_ready_i, out_data_o, "result changed while stalled")

  `ETFL_ASSERT(a_one_at_a_time, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "second command taken during a sweep")

  `ETFL_ASSERT(a_exact_is_level0, clk_i, rst_ni, (out_valid_o && out_data_o.exact_present) |-> (out_data_o.status == STATUS_OK && out_data_o.hit_level == LVL_EXACT), "exact key present but other level reported")

  `ETFL_ASSERT(a_miss_zeroed, clk_i, rst_ni, (out_valid_o && out_data_o.status == STATUS_MISS) |-> (out_data_o.hit_level == LVL_EXACT && out_data_o.out_x == '0 && out_data_o.out_y == '0 && out_data_o.out_z == '0), "miss result carries data")

endmodule

bind epipole_table_fallback_lookup etfl_checker u_etfl_checker (.*);

`default_nettype wire
